FILE: hdl/hht_pkg.sv
// ----------------------------------------------------------------------------
// hht_pkg: shared types and constants of the hopscotch hash table
// Command and status groups between controller and datapath, slot word
// layout, result codes and the hash constants.
// ----------------------------------------------------------------------------
package hht_pkg;

  // Hash constants.
  localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MUR_SEED = 64'd123;
  localparam logic [63:0] MUR_INIT = MUR_SEED ^ (MUR_M << 2);
  localparam int          MUR_R    = 47;

  // Hop bitmap geometry.
  localparam int HOP_W  = 32;
  localparam int HOP_IW = 5;

  // Item commands.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Result codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_ABSENT   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_STUCK    = 3'd4;

  // Slot read address selects.
  localparam logic [1:0] SA_PROBE = 2'd0;
  localparam logic [1:0] SA_PTR   = 2'd1;
  localparam logic [1:0] SA_CAND  = 2'd2;

  // Hop read address selects.
  localparam logic HA_HOME = 1'b0;
  localparam logic HA_CH   = 1'b1;

  // Slot write operations.
  localparam logic [1:0] SW_NONE   = 2'd0;
  localparam logic [1:0] SW_NEW    = 2'd1;
  localparam logic [1:0] SW_MOVE   = 2'd2;
  localparam logic [1:0] SW_VACATE = 2'd3;

  // Hop write operations.
  localparam logic [1:0] HW_NONE = 2'd0;
  localparam logic [1:0] HW_INS  = 2'd1;
  localparam logic [1:0] HW_MOVE = 2'd2;

  typedef struct packed {
    logic        occ;
    logic [31:0] key;
    logic [31:0] value;
  } hht_slot_t;

  typedef struct packed {
    logic       load_item;
    logic       hash_start;
    logic       hash_cand;
    logic       set_home;
    logic       set_chome;
    logic       idx_clear;
    logic       idx_one;
    logic       idx_inc;
    logic       ptr_home;
    logic       ptr_inc;
    logic       free_ptr;
    logic       free_cand;
    logic       latch_cand;
    logic       clr_step;
    logic [1:0] slot_asel;
    logic       hop_asel;
    logic [1:0] slot_wr;
    logic [1:0] hop_wr;
  } hht_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic clr_last;
    logic idx_end;
    logic bm_bit;
    logic slot_hit;
    logic slot_occ;
    logic scan_end;
    logic near;
    logic cand_near;
    logic item_cmd;
  } hht_sts_t;

endpackage

FILE: hdl/hht_hash.sv
// ----------------------------------------------------------------------------
// hht_hash: multi-cycle key hash and home slot unit
// Two multiply/xorshift rounds on one shared 32x32 multiplier, then a
// byte-serial reduction of the 64-bit hash by segment count and segment size
// using reciprocal multiplication, with a quotient and a remainder step per byte.
// ----------------------------------------------------------------------------
module hht_hash #(
  parameter int NUM_SEGMENTS = 4,
  parameter int SEGMENT_SIZE = 256
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic [31:0]                                  key_in,
  output logic                                         done,
  output logic [$clog2(NUM_SEGMENTS*SEGMENT_SIZE)-1:0] home
);

  localparam int TOTAL = NUM_SEGMENTS * SEGMENT_SIZE;
  localparam int AW    = $clog2(TOTAL);

  // Halves of the multiplier constant.
  localparam logic [31:0] M_LO = 32'(hht_pkg::MUR_M);
  localparam logic [31:0] M_HI = 32'(hht_pkg::MUR_M >> 32);

  // Moduli and their scaled reciprocals for the reduction.
  localparam logic [16:0] SEG_K    = 17'(NUM_SEGMENTS);
  localparam logic [16:0] SIZE_K   = 17'(SEGMENT_SIZE);
  localparam logic [24:0] SEG_RCP  = 25'((64'd1 << 24) / NUM_SEGMENTS);
  localparam logic [24:0] SIZE_RCP = 25'((64'd1 << 24) / SEGMENT_SIZE);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_MUL  = 2'd1;
  localparam logic [1:0] H_MOD  = 2'd2;
  localparam logic [1:0] H_HOME = 2'd3;

  logic [1:0]  state;
  logic [1:0]  ph;
  logic        rnd;
  logic [3:0]  cnt;
  logic [63:0] h;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [15:0] rn;
  logic [15:0] rs;
  logic [23:0] qn;
  logic [23:0] qs;
  logic [63:0] mix;
  logic [48:0] pn;
  logic [48:0] ps;
  logic [40:0] mn;
  logic [40:0] ms;
  logic [24:0] dn;
  logic [24:0] ds;
  logic [15:0] rn_t;
  logic [15:0] rs_t;

  // Final partial product sum of one round and its xorshift.
  always_comb begin
    mix = acc + {prod[31:0], 32'd0};
    mix = mix ^ (mix >> hht_pkg::MUR_R);
  end

  // One reduction step: the running remainder takes in the next byte. The
  // estimated quotient is low by at most one, so one correction suffices.
  always_comb begin
    pn   = {rn, h[63:56]} * SEG_RCP;
    ps   = {rs, h[63:56]} * SIZE_RCP;
    mn   = qn * SEG_K;
    ms   = qs * SIZE_K;
    dn   = {1'b0, rn, h[63:56]} - mn[24:0];
    ds   = {1'b0, rs, h[63:56]} - ms[24:0];
    rn_t = dn[15:0];
    rs_t = ds[15:0];
    if (dn >= {8'd0, SEG_K}) rn_t = 16'(dn - {8'd0, SEG_K});
    if (ds >= {8'd0, SIZE_K}) rs_t = 16'(ds - {8'd0, SIZE_K});
  end

  // Sequencer of the hash steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
      ph    <= 2'd0;
      rnd   <= 1'b0;
      cnt   <= 4'd0;
    end else begin
      done <= 1'b0;
      case (state)
        H_IDLE: begin
          if (start) begin
            state <= H_MUL;
            ph    <= 2'd0;
            rnd   <= 1'b0;
          end
        end
        H_MUL: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            rnd <= 1'b1;
            if (rnd) begin
              state <= H_MOD;
              cnt   <= 4'd0;
            end
          end
        end
        H_MOD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= H_HOME;
        end
        H_HOME: begin
          state <= H_IDLE;
          done  <= 1'b1;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        if (start) h <= hht_pkg::MUR_INIT ^ {32'd0, key_in};
      end
      H_MUL: begin
        case (ph)
          2'd0: prod <= h[31:0] * M_LO;
          2'd1: begin
            acc  <= prod;
            prod <= h[31:0] * M_HI;
          end
          2'd2: begin
            acc  <= acc + {prod[31:0], 32'd0};
            prod <= h[63:32] * M_LO;
          end
          default: h <= mix;
        endcase
        rn <= '0;
        rs <= '0;
      end
      H_MOD: begin
        if (!cnt[0]) begin
          qn <= pn[47:24];
          qs <= ps[47:24];
        end else begin
          rn <= rn_t;
          rs <= rs_t;
          h  <= {h[55:0], 8'd0};
        end
      end
      H_HOME: begin
        home <= AW'(32'(rn) * 32'(SEGMENT_SIZE) + 32'(rs));
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/hht_datapath.sv
// ----------------------------------------------------------------------------
// hht_datapath: slot and hop bitmap memories with address and compare logic
// Holds the item, scan pointers and candidate, and carries out the
// controller's read, write and register commands.
// ----------------------------------------------------------------------------
module hht_datapath #(
  parameter int NUM_SEGMENTS = 4,
  parameter int SEGMENT_SIZE = 256,
  parameter int NEIGHBORHOOD = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  hht_pkg::hht_cmd_t cmd_in,
  input  logic              in_cmd,
  input  logic [31:0]       in_key,
  input  logic [31:0]       in_value,
  output hht_pkg::hht_sts_t sts
);

  localparam int TOTAL = NUM_SEGMENTS * SEGMENT_SIZE;
  localparam int AW    = $clog2(TOTAL);
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int IW    = $clog2(NEIGHBORHOOD + 1);
  localparam int HW    = hht_pkg::HOP_W;

  hht_pkg::hht_slot_t slot_mem [TOTAL];
  logic [HW-1:0]      hop_mem  [TOTAL];

  hht_pkg::hht_slot_t slot_rd;
  logic [HW-1:0]      hop_rd;

  logic          item_cmd;
  logic [31:0]   item_key;
  logic [31:0]   item_value;
  logic [31:0]   ckey;
  logic [31:0]   cval;
  logic [AW-1:0] home;
  logic [AW-1:0] chome;
  logic [AW-1:0] free_slot;
  logic [AW-1:0] ptr;
  logic [AW-1:0] clr;
  logic [CW-1:0] cnt;
  logic [IW-1:0] idx;

  logic               hash_done;
  logic [AW-1:0]      hash_home;
  logic [31:0]        hash_key;
  logic [AW:0]        probe_sum;
  logic [AW-1:0]      probe_addr;
  logic [AW:0]        back;
  logic [AW-1:0]      cand;
  logic [AW-1:0]      dist_home;
  logic [AW-1:0]      dist_free;
  logic [AW-1:0]      dist_cand;
  logic               near;
  logic               cand_near;
  logic [HW-1:0]      clr_bit;
  logic [AW-1:0]      slot_ra;
  logic [AW-1:0]      hop_ra;
  logic               slot_we;
  logic [AW-1:0]      slot_wa;
  hht_pkg::hht_slot_t slot_wd;
  logic               hop_we;
  logic [AW-1:0]      hop_wa;
  logic [HW-1:0]      hop_wd;

  // Forward distance from slot a to slot b round the ring.
  function automatic logic [AW-1:0] ring_dist(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] t;
    t = {1'b0, b} + (AW+1)'(TOTAL) - {1'b0, a};
    if (b >= a) t = {1'b0, b} - {1'b0, a};
    return t[AW-1:0];
  endfunction

  // The hash unit serves both the item key and candidate keys.
  assign hash_key = cmd_in.hash_cand ? slot_rd.key : in_key;

  hht_hash #(
    .NUM_SEGMENTS(NUM_SEGMENTS),
    .SEGMENT_SIZE(SEGMENT_SIZE)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd_in.hash_start),
    .key_in (hash_key),
    .done   (hash_done),
    .home   (hash_home)
  );

  // Neighbor address, candidate address and distances.
  always_comb begin
    probe_sum  = {1'b0, home} + (AW+1)'(idx);
    probe_addr = probe_sum[AW-1:0];
    if (probe_sum >= (AW+1)'(TOTAL)) probe_addr = AW'(probe_sum - (AW+1)'(TOTAL));
    back = (AW+1)'(NEIGHBORHOOD) - (AW+1)'(idx);
    cand = AW'({1'b0, free_slot} + (AW+1)'(TOTAL) - back);
    if ({1'b0, free_slot} >= back) cand = AW'({1'b0, free_slot} - back);
    dist_home = ring_dist(home, free_slot);
    dist_free = ring_dist(chome, free_slot);
    dist_cand = ring_dist(chome, cand);
    near      = {1'b0, dist_home} < (AW+1)'(NEIGHBORHOOD);
    cand_near = {1'b0, dist_free} < (AW+1)'(NEIGHBORHOOD);
    clr_bit   = '0;
    if ({1'b0, dist_cand} < (AW+1)'(HW)) clr_bit = HW'(1) << dist_cand[hht_pkg::HOP_IW-1:0];
  end

  // Read address selection.
  always_comb begin
    case (cmd_in.slot_asel)
      hht_pkg::SA_PROBE: slot_ra = probe_addr;
      hht_pkg::SA_PTR:   slot_ra = ptr;
      hht_pkg::SA_CAND:  slot_ra = cand;
      default:           slot_ra = ptr;
    endcase
    hop_ra = (cmd_in.hop_asel == hht_pkg::HA_CH) ? chome : home;
  end

  // Write port selection; the clearing pass takes both memories.
  always_comb begin
    slot_we = 1'b1;
    slot_wa = free_slot;
    slot_wd = '{occ: 1'b1, key: item_key, value: item_value};
    case (cmd_in.slot_wr)
      hht_pkg::SW_NEW:    ;
      hht_pkg::SW_MOVE:   slot_wd = '{occ: 1'b1, key: ckey, value: cval};
      hht_pkg::SW_VACATE: begin
        slot_wa = cand;
        slot_wd = '{occ: 1'b0, key: ckey, value: cval};
      end
      default:            slot_we = 1'b0;
    endcase
    hop_we = 1'b1;
    hop_wa = home;
    hop_wd = hop_rd | (HW'(1) << dist_home[hht_pkg::HOP_IW-1:0]);
    case (cmd_in.hop_wr)
      hht_pkg::HW_INS:  ;
      hht_pkg::HW_MOVE: begin
        hop_wa = chome;
        hop_wd = (hop_rd & ~clr_bit) | (HW'(1) << dist_free[hht_pkg::HOP_IW-1:0]);
      end
      default:          hop_we = 1'b0;
    endcase
    if (cmd_in.clr_step) begin
      slot_we = 1'b1;
      slot_wa = clr;
      slot_wd = '0;
      hop_we  = 1'b1;
      hop_wa  = clr;
      hop_wd  = '0;
    end
  end

  // Slot memory.
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end

  // Hop bitmap memory.
  always_ff @(posedge clk) begin
    if (hop_we) hop_mem[hop_wa] <= hop_wd;
    hop_rd <= hop_mem[hop_ra];
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd_in.clr_step) begin
      clr <= clr + AW'(1);
    end
  end

  // Item, pointer and candidate registers.
  always_ff @(posedge clk) begin
    if (cmd_in.load_item) begin
      item_cmd   <= in_cmd;
      item_key   <= in_key;
      item_value <= in_value;
    end
    if (cmd_in.set_home) home <= hash_home;
    if (cmd_in.set_chome) chome <= hash_home;
    if (cmd_in.idx_clear) idx <= '0;
    else if (cmd_in.idx_one) idx <= IW'(1);
    else if (cmd_in.idx_inc) idx <= idx + IW'(1);
    if (cmd_in.ptr_home) begin
      ptr <= home;
      cnt <= '0;
    end else if (cmd_in.ptr_inc) begin
      ptr <= (ptr == AW'(TOTAL - 1)) ? '0 : ptr + AW'(1);
      cnt <= cnt + CW'(1);
    end
    if (cmd_in.free_ptr) free_slot <= ptr;
    else if (cmd_in.free_cand) free_slot <= cand;
    if (cmd_in.latch_cand) begin
      ckey <= slot_rd.key;
      cval <= slot_rd.value;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.hash_done = hash_done;
    sts.clr_last  = (clr == AW'(TOTAL - 1));
    sts.idx_end   = (idx == IW'(NEIGHBORHOOD));
    sts.bm_bit    = hop_rd[hht_pkg::HOP_IW'(idx)];
    sts.slot_hit  = slot_rd.occ && (slot_rd.key == item_key);
    sts.slot_occ  = slot_rd.occ;
    sts.scan_end  = (cnt == CW'(TOTAL));
    sts.near      = near;
    sts.cand_near = cand_near;
    sts.item_cmd  = item_cmd;
  end

  // A new key is placed only inside its home neighborhood.
  a_new_near: assert property (@(posedge clk) disable iff (rst)
    (cmd_in.slot_wr == hht_pkg::SW_NEW) |-> near)
    else $error("new key written outside its neighborhood");

  // A moved entry lands inside its own home neighborhood.
  a_move_near: assert property (@(posedge clk) disable iff (rst)
    (cmd_in.hop_wr == hht_pkg::HW_MOVE) |-> cand_near)
    else $error("entry moved outside its neighborhood");

endmodule

FILE: hdl/hht_ctrl.sv
// ----------------------------------------------------------------------------
// hht_ctrl: controller of the hopscotch hash table
// Sequences the clearing pass, lookup scan, free slot search and
// displacement, and holds the result word register.
// ----------------------------------------------------------------------------
module hht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  input  hht_pkg::hht_sts_t sts,
  output hht_pkg::hht_cmd_t cmd_out
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HHASH  = 4'd2;
  localparam logic [3:0] S_LHOP   = 4'd3;
  localparam logic [3:0] S_LISSUE = 4'd4;
  localparam logic [3:0] S_LCHECK = 4'd5;
  localparam logic [3:0] S_FISSUE = 4'd6;
  localparam logic [3:0] S_FCHECK = 4'd7;
  localparam logic [3:0] S_DCHECK = 4'd8;
  localparam logic [3:0] S_IHOP   = 4'd9;
  localparam logic [3:0] S_CISSUE = 4'd10;
  localparam logic [3:0] S_CCHECK = 4'd11;
  localparam logic [3:0] S_CHASH  = 4'd12;
  localparam logic [3:0] S_CTEST  = 4'd13;
  localparam logic [3:0] S_CMOVE  = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] res;
  logic [2:0] res_next;
  logic       out_load;

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // Next state and datapath commands.
  always_comb begin
    state_next        = state;
    res_next          = res;
    cmd_out           = '0;
    cmd_out.slot_asel = hht_pkg::SA_PROBE;
    cmd_out.hop_asel  = hht_pkg::HA_HOME;
    cmd_out.slot_wr   = hht_pkg::SW_NONE;
    cmd_out.hop_wr    = hht_pkg::HW_NONE;
    case (state)
      S_CLEAR: begin
        cmd_out.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_out.load_item  = 1'b1;
          cmd_out.hash_start = 1'b1;
          state_next         = S_HHASH;
        end
      end
      S_HHASH: begin
        if (sts.hash_done) begin
          cmd_out.set_home  = 1'b1;
          cmd_out.idx_clear = 1'b1;
          state_next        = S_LHOP;
        end
      end
      S_LHOP: state_next = S_LISSUE;
      S_LISSUE: begin
        if (sts.idx_end) begin
          if (sts.item_cmd == hht_pkg::CMD_INSERT) begin
            cmd_out.ptr_home = 1'b1;
            state_next       = S_FISSUE;
          end else begin
            res_next   = hht_pkg::ST_ABSENT;
            state_next = S_DONE;
          end
        end else if (sts.bm_bit) begin
          state_next = S_LCHECK;
        end else begin
          cmd_out.idx_inc = 1'b1;
        end
      end
      S_LCHECK: begin
        if (sts.slot_hit) begin
          res_next   = hht_pkg::ST_PRESENT;
          state_next = S_DONE;
        end else begin
          cmd_out.idx_inc = 1'b1;
          state_next      = S_LISSUE;
        end
      end
      S_FISSUE: begin
        cmd_out.slot_asel = hht_pkg::SA_PTR;
        if (sts.scan_end) begin
          res_next   = hht_pkg::ST_FULL;
          state_next = S_DONE;
        end else begin
          state_next = S_FCHECK;
        end
      end
      S_FCHECK: begin
        if (!sts.slot_occ) begin
          cmd_out.free_ptr = 1'b1;
          state_next       = S_DCHECK;
        end else begin
          cmd_out.ptr_inc = 1'b1;
          state_next      = S_FISSUE;
        end
      end
      S_DCHECK: begin
        if (sts.near) begin
          cmd_out.slot_wr = hht_pkg::SW_NEW;
          state_next      = S_IHOP;
        end else begin
          cmd_out.idx_one = 1'b1;
          state_next      = S_CISSUE;
        end
      end
      S_IHOP: begin
        cmd_out.hop_wr = hht_pkg::HW_INS;
        res_next       = hht_pkg::ST_INSERTED;
        state_next     = S_DONE;
      end
      S_CISSUE: begin
        cmd_out.slot_asel = hht_pkg::SA_CAND;
        if (sts.idx_end) begin
          res_next   = hht_pkg::ST_STUCK;
          state_next = S_DONE;
        end else begin
          state_next = S_CCHECK;
        end
      end
      S_CCHECK: begin
        if (sts.slot_occ) begin
          cmd_out.latch_cand = 1'b1;
          cmd_out.hash_start = 1'b1;
          cmd_out.hash_cand  = 1'b1;
          state_next         = S_CHASH;
        end else begin
          cmd_out.idx_inc = 1'b1;
          state_next      = S_CISSUE;
        end
      end
      S_CHASH: begin
        if (sts.hash_done) begin
          cmd_out.set_chome = 1'b1;
          state_next        = S_CTEST;
        end
      end
      S_CTEST: begin
        cmd_out.hop_asel = hht_pkg::HA_CH;
        if (sts.cand_near) begin
          cmd_out.slot_wr = hht_pkg::SW_MOVE;
          state_next      = S_CMOVE;
        end else begin
          cmd_out.idx_inc = 1'b1;
          state_next      = S_CISSUE;
        end
      end
      S_CMOVE: begin
        cmd_out.slot_wr   = hht_pkg::SW_VACATE;
        cmd_out.hop_wr    = hht_pkg::HW_MOVE;
        cmd_out.free_cand = 1'b1;
        state_next        = S_DCHECK;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (out_load) status <= res;
  end

  // The hash unit finishes only while the controller waits on it.
  a_hash_wait: assert property (@(posedge clk) disable iff (rst)
    sts.hash_done |-> (state == S_HHASH || state == S_CHASH))
    else $error("hash result arrived outside a wait state");

  // An accepted word always starts with the item hash.
  a_accept_hash: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_HHASH))
    else $error("accepted word did not start hashing");

  // Result words carry only defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= hht_pkg::ST_STUCK))
    else $error("undefined result code");

endmodule

FILE: hdl/hopscotch_hash_table.sv
// ----------------------------------------------------------------------------
// hopscotch_hash_table: hopscotch hash table with 32-bit keys and values
// Controller and datapath with hashed home slots and displacement on insert.
// ----------------------------------------------------------------------------
// One word at a time. After reset a clearing pass over all NUM_SEGMENTS *
// SEGMENT_SIZE slots (1024 by default) runs before the first word is taken.
// Each word first goes through the key hash unit (eight multiplier steps on
// one shared 32x32 multiplier, then a byte-serial reduction). A lookup then
// checks the hop bit of each neighbor in turn and reads the slot of each
// neighbor whose hop bit is set. An insert adds a search of slots for a free
// slot and, while the free slot lies outside the neighborhood, a check of
// candidates plus a full hash for each occupied candidate; insert time thus
// depends on table load. The result word waits in an output register.
module hopscotch_hash_table #(
  parameter int NUM_SEGMENTS = 4,
  parameter int SEGMENT_SIZE = 256,
  parameter int NEIGHBORHOOD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status
);

  hht_pkg::hht_cmd_t dp_cmd;
  hht_pkg::hht_sts_t dp_sts;

  hht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .sts       (dp_sts),
    .cmd_out   (dp_cmd)
  );

  hht_datapath #(
    .NUM_SEGMENTS(NUM_SEGMENTS),
    .SEGMENT_SIZE(SEGMENT_SIZE),
    .NEIGHBORHOOD(NEIGHBORHOOD)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd_in   (dp_cmd),
    .in_cmd   (cmd),
    .in_key   (key),
    .in_value (value),
    .sts      (dp_sts)
  );

endmodule
